// File: hdl/bfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfd_pkg;

   // Word field widths and fixed-point positions
   localparam int COORD_W          = 20;
   localparam int DEPTH_W          = 32;
   localparam int COORD_FRAC_BITS  = 4;
   localparam int WEIGHT_FRAC_BITS = 16;
   localparam int PIXEL_INDEX_BITS = 12;
   localparam int WEIGHT_W         = WEIGHT_FRAC_BITS + 1;

   // Geometry: doubled coordinates and pixel centres share one signed width
   localparam int PT_W   = (COORD_W + 1 > PIXEL_INDEX_BITS + COORD_FRAC_BITS + 2) ?
                           COORD_W + 1 : PIXEL_INDEX_BITS + COORD_FRAC_BITS + 2;
   localparam int EDGE_W = PT_W + 1;
   localparam int PROD_W = 2 * EDGE_W;
   localparam int DET_W  = PROD_W + 1;
   localparam int DIV_W  = DET_W - 1;

   // Depth path widths
   localparam int MAG_W  = DEPTH_W;
   localparam int M2_W   = 2 * MAG_W;
   localparam int P_W    = 3 * MAG_W;
   localparam int NUM_W  = P_W + WEIGHT_FRAC_BITS;
   localparam int NHI_W  = NUM_W - DEPTH_W;
   localparam int PP_W   = MAG_W + WEIGHT_W;
   localparam int TERM_W = M2_W + WEIGHT_W;
   localparam int SUM_W  = TERM_W + 3;
   localparam int SMAG_W = TERM_W + 2;

   // Pipeline depth from accepted word to result strobe
   localparam int LAT = 13 + WEIGHT_FRAC_BITS + DEPTH_W;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE     = WEIGHT_W'(1) << WEIGHT_FRAC_BITS;
   localparam logic [DEPTH_W-1:0]  DEPTH_POS_MAX  = {1'b0, {(DEPTH_W-1){1'b1}}};
   localparam logic [DEPTH_W-1:0]  DEPTH_NEG_MAG  = {1'b1, {(DEPTH_W-1){1'b0}}};

   typedef logic signed [EDGE_W-1:0] edge_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [DET_W-1:0]  det_type;

   // Edge vectors and depth magnitudes
   typedef struct packed {
      edge_type             e0x, e0y, e1x, e1y, e2x, e2y;
      logic [MAG_W-1:0]     m0, m1, m2;
      logic                 s0, s1, s2;
   } a_type;

   typedef struct packed {
      prod_type pd0, pd1, pd2, pd3, pd4, pd5;
   } b_type;

   typedef struct packed {
      det_type          det, nu, nv;
      logic [M2_W-1:0]  plo, phi;
   } c_type;

   typedef struct packed {
      det_type detf, nuf, nvf;
   } d_type;

   // Per-word control and depth operands carried down the pipe
   typedef struct packed {
      logic                         degen;
      logic                         hit;
      logic                         psign;
      logic [2:0]                   tsign;
      logic [M2_W-1:0]              m01, m02, m12;
      logic [MAG_W-1:0]             m2;
      logic [P_W-1:0]               p;
      logic [WEIGHT_FRAC_BITS-1:0]  uq, vq;
      logic [WEIGHT_W-1:0]          wq;
   } ctl_type;

   typedef struct packed {
      logic [PP_W-1:0] pw_lo, pw_hi, pv_lo, pv_hi, pu_lo, pu_hi;
   } g_type;

   typedef struct packed {
      logic [TERM_W-1:0] tw, tv, tu;
   } h_type;

   typedef struct packed {
      logic [SUM_W-1:0] sw, sv, su;
   } i_type;

   typedef struct packed {
      logic [SMAG_W-1:0] smag;
      logic              negs;
      logic              szero;
   } k_type;

   typedef struct packed {
      logic big;
      logic nzero;
      logic szero;
      logic negeff;
   } qf_type;

   function automatic edge_type dbl_coord(input logic signed [COORD_W-1:0] c);
      dbl_coord = {{(EDGE_W-COORD_W-1){c[COORD_W-1]}}, c, 1'b0};
   endfunction

   // Pixel centre on the doubled grid: index * 2^(F+1) + 2^F
   function automatic edge_type pix_point(input logic [PIXEL_INDEX_BITS-1:0] p);
      edge_type t;
      t = EDGE_W'({1'b0, p});
      pix_point = (t <<< (COORD_FRAC_BITS + 1)) | (edge_type'(1) <<< COORD_FRAC_BITS);
   endfunction

   function automatic logic [MAG_W-1:0] depth_mag(input logic signed [DEPTH_W-1:0] d);
      depth_mag = d[DEPTH_W-1] ? (~d + 1'b1) : d;
   endfunction

endpackage

`default_nettype wire

// File: hdl/barycentric_fragment_test.sv
`timescale 1ns / 1ps
`default_nettype none

// Pixel-in-triangle test with barycentric weights and perspective depth.
// Input channel: drive the triangle, depths and pixel on the req_ ports and
// raise start; the word is taken at any edge where start is high and busy
// is low. busy stays low: a new word may enter on every cycle.
// Result channel: rsp_strobe is high for one cycle with the result on the
// rsp_ ports; the receiver has no way to hold it off and must take it then.
// Throughput is one word per cycle. The pipeline length LAT, from the
// accepting edge to the edge that takes the result, is set by the two
// bit-per-stage dividers: the weight divider (one stage per weight
// fraction bit) and the depth divider (one stage per result bit), plus
// multiplier and adder stages around them.
// Results leave in acceptance order. Reset clears only the valid chain, so
// no strobe appears for words in flight at reset.
// Outside or degenerate pixels report zero weights and zero depth.
module barycentric_fragment_test (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic signed [bfd_pkg::COORD_W-1:0]       req_vertex0_x,
   input  logic signed [bfd_pkg::COORD_W-1:0]       req_vertex0_y,
   input  logic signed [bfd_pkg::COORD_W-1:0]       req_vertex1_x,
   input  logic signed [bfd_pkg::COORD_W-1:0]       req_vertex1_y,
   input  logic signed [bfd_pkg::COORD_W-1:0]       req_vertex2_x,
   input  logic signed [bfd_pkg::COORD_W-1:0]       req_vertex2_y,
   input  logic signed [bfd_pkg::DEPTH_W-1:0]       req_depth0,
   input  logic signed [bfd_pkg::DEPTH_W-1:0]       req_depth1,
   input  logic signed [bfd_pkg::DEPTH_W-1:0]       req_depth2,
   input  logic [bfd_pkg::PIXEL_INDEX_BITS-1:0]     req_pixel_x,
   input  logic [bfd_pkg::PIXEL_INDEX_BITS-1:0]     req_pixel_y,
   output logic                                     rsp_strobe,
   output logic                                     rsp_inside_res,
   output logic                                     rsp_degenerate,
   output logic [bfd_pkg::WEIGHT_W-1:0]             rsp_weight_u,
   output logic [bfd_pkg::WEIGHT_W-1:0]             rsp_weight_v,
   output logic [bfd_pkg::WEIGHT_W-1:0]             rsp_weight_w,
   output logic signed [bfd_pkg::DEPTH_W-1:0]       rsp_pixel_depth
);
   import bfd_pkg::*;

   logic [LAT-1:0] vld_ff;

   a_type   a_ff, a_in;
   b_type   b_ff, b_in;
   c_type   c_ff, c_in;
   d_type   d_ff, d_in;
   ctl_type ctl_b_ff, ctl_b_in, ctl_c_ff, ctl_d_ff, ctl_d_in;

   // weight divider chain
   logic [DIV_W-1:0]            ur_ff [0:WEIGHT_FRAC_BITS];
   logic [DIV_W-1:0]            vr_ff [0:WEIGHT_FRAC_BITS];
   logic [DIV_W-1:0]            dv_ff [0:WEIGHT_FRAC_BITS];
   logic [WEIGHT_FRAC_BITS-1:0] uq_ff [0:WEIGHT_FRAC_BITS];
   logic [WEIGHT_FRAC_BITS-1:0] vq_ff [0:WEIGHT_FRAC_BITS];
   ctl_type                     uctl_ff [0:WEIGHT_FRAC_BITS];
   ctl_type                     uctl_in;
   logic signed [DET_W:0]       nsum;

   ctl_type ctl_f_ff, ctl_f_in, ctl_g_ff, ctl_h_ff, ctl_i_ff, ctl_j_ff, ctl_k_ff;
   g_type   g_ff, g_in;
   h_type   h_ff, h_in;
   i_type   i_ff, i_in;
   logic [SUM_W-1:0] j_ff, j_in;
   k_type   k_ff, k_in;

   // depth divider chain
   logic [SMAG_W-1:0]  qr_ff  [0:DEPTH_W];
   logic [SMAG_W-1:0]  qs_ff  [0:DEPTH_W];
   logic [DEPTH_W-1:0] qq_ff  [0:DEPTH_W];
   logic [DEPTH_W-1:0] qlo_ff [0:DEPTH_W];
   qf_type             qf_ff  [0:DEPTH_W];
   ctl_type            qctl_ff [0:DEPTH_W];
   qf_type             qf_in;
   logic [NUM_W-1:0]   num;
   logic [NHI_W-1:0]   nhi;

   logic                       rsp_inside_ff, rsp_degen_ff;
   logic [WEIGHT_W-1:0]        rsp_u_ff, rsp_v_ff, rsp_w_ff;
   logic [DEPTH_W-1:0]         rsp_depth_ff, depth_in, dmag;
   logic                       sat;

   assign busy = 1'b0;

   // valid chain, one bit per stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start & ~busy};
      end
   end

   // stage A: edge vectors, depth magnitudes
   always_comb begin
      a_in.e0x = dbl_coord(req_vertex2_x) - dbl_coord(req_vertex0_x);
      a_in.e0y = dbl_coord(req_vertex2_y) - dbl_coord(req_vertex0_y);
      a_in.e1x = dbl_coord(req_vertex1_x) - dbl_coord(req_vertex0_x);
      a_in.e1y = dbl_coord(req_vertex1_y) - dbl_coord(req_vertex0_y);
      a_in.e2x = pix_point(req_pixel_x) - dbl_coord(req_vertex0_x);
      a_in.e2y = pix_point(req_pixel_y) - dbl_coord(req_vertex0_y);
      a_in.m0  = depth_mag(req_depth0);
      a_in.m1  = depth_mag(req_depth1);
      a_in.m2  = depth_mag(req_depth2);
      a_in.s0  = req_depth0[DEPTH_W-1];
      a_in.s1  = req_depth1[DEPTH_W-1];
      a_in.s2  = req_depth2[DEPTH_W-1];
   end

   // stage B: cross-product terms and pairwise depth products
   always_comb begin
      b_in.pd0 = PROD_W'(a_ff.e0x) * PROD_W'(a_ff.e1y);
      b_in.pd1 = PROD_W'(a_ff.e0y) * PROD_W'(a_ff.e1x);
      b_in.pd2 = PROD_W'(a_ff.e2x) * PROD_W'(a_ff.e1y);
      b_in.pd3 = PROD_W'(a_ff.e2y) * PROD_W'(a_ff.e1x);
      b_in.pd4 = PROD_W'(a_ff.e0x) * PROD_W'(a_ff.e2y);
      b_in.pd5 = PROD_W'(a_ff.e0y) * PROD_W'(a_ff.e2x);
      ctl_b_in       = '0;
      ctl_b_in.m01   = M2_W'(a_ff.m0) * M2_W'(a_ff.m1);
      ctl_b_in.m02   = M2_W'(a_ff.m0) * M2_W'(a_ff.m2);
      ctl_b_in.m12   = M2_W'(a_ff.m1) * M2_W'(a_ff.m2);
      ctl_b_in.m2    = a_ff.m2;
      ctl_b_in.psign = a_ff.s0 ^ a_ff.s1 ^ a_ff.s2;
      ctl_b_in.tsign = {a_ff.s0 ^ a_ff.s1, a_ff.s0 ^ a_ff.s2, a_ff.s1 ^ a_ff.s2};
   end

   // stage C: determinant and numerators, triple product halves
   always_comb begin
      c_in.det = DET_W'(b_ff.pd0) - DET_W'(b_ff.pd1);
      c_in.nu  = DET_W'(b_ff.pd2) - DET_W'(b_ff.pd3);
      c_in.nv  = DET_W'(b_ff.pd4) - DET_W'(b_ff.pd5);
      c_in.plo = M2_W'(ctl_b_ff.m01[MAG_W-1:0]) * M2_W'(ctl_b_ff.m2);
      c_in.phi = M2_W'(ctl_b_ff.m01[M2_W-1:MAG_W]) * M2_W'(ctl_b_ff.m2);
   end

   // stage D: orient to positive determinant, assemble triple product
   always_comb begin
      d_in.detf = c_ff.det[DET_W-1] ? -c_ff.det : c_ff.det;
      d_in.nuf  = c_ff.det[DET_W-1] ? -c_ff.nu  : c_ff.nu;
      d_in.nvf  = c_ff.det[DET_W-1] ? -c_ff.nv  : c_ff.nv;
      ctl_d_in       = ctl_c_ff;
      ctl_d_in.degen = (c_ff.det == '0);
      ctl_d_in.p     = P_W'(c_ff.plo) + (P_W'(c_ff.phi) << MAG_W);
   end

   // stage E: inside decision, load weight dividers
   always_comb begin
      nsum = (DET_W+1)'(d_ff.nuf) + (DET_W+1)'(d_ff.nvf);
      uctl_in     = ctl_d_ff;
      uctl_in.hit = !ctl_d_ff.degen && !d_ff.nuf[DET_W-1] && !d_ff.nvf[DET_W-1] &&
                    (d_ff.nuf <= d_ff.detf) && (d_ff.nvf <= d_ff.detf) &&
                    (nsum < (DET_W+1)'(d_ff.detf));
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      ctl_b_ff   <= ctl_b_in;
      c_ff       <= c_in;
      ctl_c_ff   <= ctl_b_ff;
      d_ff       <= d_in;
      ctl_d_ff   <= ctl_d_in;
      ur_ff[0]   <= d_ff.nuf[DIV_W-1:0];
      vr_ff[0]   <= d_ff.nvf[DIV_W-1:0];
      dv_ff[0]   <= d_ff.detf[DIV_W-1:0];
      uq_ff[0]   <= '0;
      vq_ff[0]   <= '0;
      uctl_ff[0] <= uctl_in;
   end

   // weight dividers: one quotient bit per stage
   for (genvar k = 0; k < WEIGHT_FRAC_BITS; k++) begin : g_wdiv
      logic [DIV_W:0] ur2, vr2;
      logic           u_ge, v_ge;
      always_comb begin
         ur2  = {ur_ff[k], 1'b0};
         vr2  = {vr_ff[k], 1'b0};
         u_ge = (ur2 >= {1'b0, dv_ff[k]});
         v_ge = (vr2 >= {1'b0, dv_ff[k]});
      end
      always_ff @(posedge clock) begin
         ur_ff[k+1]   <= u_ge ? DIV_W'(ur2 - {1'b0, dv_ff[k]}) : ur2[DIV_W-1:0];
         vr_ff[k+1]   <= v_ge ? DIV_W'(vr2 - {1'b0, dv_ff[k]}) : vr2[DIV_W-1:0];
         uq_ff[k+1]   <= {uq_ff[k][WEIGHT_FRAC_BITS-2:0], u_ge};
         vq_ff[k+1]   <= {vq_ff[k][WEIGHT_FRAC_BITS-2:0], v_ge};
         dv_ff[k+1]   <= dv_ff[k];
         uctl_ff[k+1] <= uctl_ff[k];
      end
   end

   // stage F: third weight
   always_comb begin
      ctl_f_in    = uctl_ff[WEIGHT_FRAC_BITS];
      ctl_f_in.uq = uq_ff[WEIGHT_FRAC_BITS];
      ctl_f_in.vq = vq_ff[WEIGHT_FRAC_BITS];
      ctl_f_in.wq = WEIGHT_ONE - WEIGHT_W'(uq_ff[WEIGHT_FRAC_BITS])
                               - WEIGHT_W'(vq_ff[WEIGHT_FRAC_BITS]);
   end

   // stage G: weight times depth-pair, split in halves
   always_comb begin
      g_in.pw_lo = PP_W'(ctl_f_ff.m12[MAG_W-1:0])    * PP_W'(ctl_f_ff.wq);
      g_in.pw_hi = PP_W'(ctl_f_ff.m12[M2_W-1:MAG_W]) * PP_W'(ctl_f_ff.wq);
      g_in.pv_lo = PP_W'(ctl_f_ff.m02[MAG_W-1:0])    * PP_W'(ctl_f_ff.vq);
      g_in.pv_hi = PP_W'(ctl_f_ff.m02[M2_W-1:MAG_W]) * PP_W'(ctl_f_ff.vq);
      g_in.pu_lo = PP_W'(ctl_f_ff.m01[MAG_W-1:0])    * PP_W'(ctl_f_ff.uq);
      g_in.pu_hi = PP_W'(ctl_f_ff.m01[M2_W-1:MAG_W]) * PP_W'(ctl_f_ff.uq);
   end

   // stage H: recombine halves
   always_comb begin
      h_in.tw = TERM_W'(g_ff.pw_lo) + (TERM_W'(g_ff.pw_hi) << MAG_W);
      h_in.tv = TERM_W'(g_ff.pv_lo) + (TERM_W'(g_ff.pv_hi) << MAG_W);
      h_in.tu = TERM_W'(g_ff.pu_lo) + (TERM_W'(g_ff.pu_hi) << MAG_W);
   end

   // stage I: apply term signs
   always_comb begin
      i_in.sw = ctl_h_ff.tsign[0] ? SUM_W'(0) - SUM_W'(h_ff.tw) : SUM_W'(h_ff.tw);
      i_in.sv = ctl_h_ff.tsign[1] ? SUM_W'(0) - SUM_W'(h_ff.tv) : SUM_W'(h_ff.tv);
      i_in.su = ctl_h_ff.tsign[2] ? SUM_W'(0) - SUM_W'(h_ff.tu) : SUM_W'(h_ff.tu);
   end

   // stage J: weighted depth sum
   assign j_in = i_ff.sw + i_ff.sv + i_ff.su;

   // stage K: sum magnitude and sign
   always_comb begin
      k_in.negs  = j_ff[SUM_W-1];
      k_in.smag  = SMAG_W'(j_ff[SUM_W-1] ? SUM_W'(0) - j_ff : j_ff);
      k_in.szero = (j_ff == '0);
   end

   always_ff @(posedge clock) begin
      ctl_f_ff <= ctl_f_in;
      g_ff     <= g_in;
      ctl_g_ff <= ctl_f_ff;
      h_ff     <= h_in;
      ctl_h_ff <= ctl_g_ff;
      i_ff     <= i_in;
      ctl_i_ff <= ctl_h_ff;
      j_ff     <= j_in;
      ctl_j_ff <= ctl_i_ff;
      k_ff     <= k_in;
      ctl_k_ff <= ctl_j_ff;
   end

   // stage L: overflow check, load depth divider
   always_comb begin
      num          = NUM_W'(ctl_k_ff.p) << WEIGHT_FRAC_BITS;
      nhi          = num[NUM_W-1:DEPTH_W];
      qf_in.big    = (SMAG_W'(nhi) >= k_ff.smag);
      qf_in.nzero  = (ctl_k_ff.p == '0);
      qf_in.szero  = k_ff.szero;
      qf_in.negeff = k_ff.szero ? ctl_k_ff.psign : (ctl_k_ff.psign ^ k_ff.negs);
   end

   always_ff @(posedge clock) begin
      qr_ff[0]   <= SMAG_W'(nhi);
      qs_ff[0]   <= k_ff.smag;
      qq_ff[0]   <= '0;
      qlo_ff[0]  <= num[DEPTH_W-1:0];
      qf_ff[0]   <= qf_in;
      qctl_ff[0] <= ctl_k_ff;
   end

   // depth divider: one quotient bit per stage
   for (genvar k = 0; k < DEPTH_W; k++) begin : g_ddiv
      logic [SMAG_W:0] r2;
      logic            ge;
      always_comb begin
         r2 = {qr_ff[k], qlo_ff[k][DEPTH_W-1]};
         ge = (r2 >= {1'b0, qs_ff[k]});
      end
      always_ff @(posedge clock) begin
         qr_ff[k+1]   <= ge ? SMAG_W'(r2 - {1'b0, qs_ff[k]}) : r2[SMAG_W-1:0];
         qs_ff[k+1]   <= qs_ff[k];
         qq_ff[k+1]   <= {qq_ff[k][DEPTH_W-2:0], ge};
         qlo_ff[k+1]  <= qlo_ff[k] << 1;
         qf_ff[k+1]   <= qf_ff[k];
         qctl_ff[k+1] <= qctl_ff[k];
      end
   end

   // stage M: saturation and result formatting
   always_comb begin
      sat = qf_ff[DEPTH_W].szero | qf_ff[DEPTH_W].big |
            (qq_ff[DEPTH_W][DEPTH_W-1] & (|qq_ff[DEPTH_W][DEPTH_W-2:0]));
      dmag = sat ? DEPTH_NEG_MAG : qq_ff[DEPTH_W];
      if (qf_ff[DEPTH_W].nzero) begin
         depth_in = '0;
      end else if (qf_ff[DEPTH_W].negeff) begin
         depth_in = DEPTH_W'(0) - dmag;
      end else if (sat || qq_ff[DEPTH_W][DEPTH_W-1]) begin
         depth_in = DEPTH_POS_MAX;
      end else begin
         depth_in = qq_ff[DEPTH_W];
      end
   end

   always_ff @(posedge clock) begin
      rsp_inside_ff <= qctl_ff[DEPTH_W].hit;
      rsp_degen_ff  <= qctl_ff[DEPTH_W].degen;
      rsp_u_ff      <= qctl_ff[DEPTH_W].hit ? WEIGHT_W'(qctl_ff[DEPTH_W].uq) : '0;
      rsp_v_ff      <= qctl_ff[DEPTH_W].hit ? WEIGHT_W'(qctl_ff[DEPTH_W].vq) : '0;
      rsp_w_ff      <= qctl_ff[DEPTH_W].hit ? qctl_ff[DEPTH_W].wq : '0;
      rsp_depth_ff  <= qctl_ff[DEPTH_W].hit ? depth_in : '0;
   end

   assign rsp_strobe      = vld_ff[LAT-1];
   assign rsp_inside_res  = rsp_inside_ff;
   assign rsp_degenerate  = rsp_degen_ff;
   assign rsp_weight_u    = rsp_u_ff;
   assign rsp_weight_v    = rsp_v_ff;
   assign rsp_weight_w    = rsp_w_ff;
   assign rsp_pixel_depth = rsp_depth_ff;

   // checks
   a_degen_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_degenerate |-> !rsp_inside_res)
      else $error("degenerate triangle reported inside");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_inside_res |->
         rsp_weight_u == '0 && rsp_weight_v == '0 && rsp_weight_w == '0 &&
         rsp_pixel_depth == '0)
      else $error("outside pixel with nonzero weights or depth");

   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_inside_res |->
         (WEIGHT_W+2)'(rsp_weight_u) + (WEIGHT_W+2)'(rsp_weight_v) +
         (WEIGHT_W+2)'(rsp_weight_w) == (WEIGHT_W+2)'(WEIGHT_ONE))
      else $error("weights do not sum to one");

   a_div_load: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] && uctl_ff[0].hit |-> ur_ff[0] < dv_ff[0] && vr_ff[0] < dv_ff[0])
      else $error("weight divider loaded with numerator not below determinant");

endmodule

`default_nettype wire
